[rtl/base_n_digit_counter_assert.svh]
// assertion macros for the base-n digit counter
// used by the top level only, no other dependencies
`ifndef BASE_N_DIGIT_COUNTER_ASSERT_SVH
`define BASE_N_DIGIT_COUNTER_ASSERT_SVH

// same-cycle implication
`define BNDC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BNDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/bndc_pkg.sv]
// shared types and constants of the base-n digit counter
// no dependencies
package bndc_pkg;

   localparam int MAX_DIGITS  = 16;
   localparam int DIGIT_BITS  = 4;
   localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
   localparam int NUM_W       = DIGIT_BITS + 1;
   localparam int CFG_W       = 5;
   localparam int CNT_W       = 5;
   localparam int CSR_IDX_W   = 1;
   localparam int WORD_W      = MAX_DIGITS * DIGIT_BITS;
   localparam int LOAD_W      = 31;
   localparam int WORK_W      = 32;
   localparam int DIV_STEPS   = 8;
   localparam int DIV_PASSES  = WORK_W / DIV_STEPS;
   localparam int PASS_W      = $clog2(DIV_PASSES);
   localparam int RADIX_MIN   = 2;
   localparam int RADIX_MAX   = 1 << DIGIT_BITS;
   localparam int RADIX_RESET = 2;
   localparam int COUNT_RESET = 8;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_BAD  = 2'd1,
      ST_WRAP = 2'd2,
      ST_BIG  = 2'd3
   } status_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIX  = 1'b0,
      CSR_DIGITS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_STEP_INIT,
      S_STEP_CARRY,
      S_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic div_run;
      logic step_begin;
      logic carry_run;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic bad;
      logic carry_stop;
   } sts_type;

endpackage

[rtl/bndc_ctrl.sv]
// controller state machine of the base-n digit counter
// depends on bndc_pkg
module bndc_ctrl import bndc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    req_op,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy,
   output logic    rsp_valid
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = (req_op == OP_STEP) ? S_STEP_INIT : S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.div_run = 1'b1;
            if (sts.div_last) state_in = S_FINISH;
         end
         S_STEP_INIT: begin
            cmd.step_begin = 1'b1;
            state_in       = sts.bad ? S_FINISH : S_STEP_CARRY;
         end
         S_STEP_CARRY: begin
            cmd.carry_run = 1'b1;
            if (sts.carry_stop) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.publish  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/bndc_dpath.sv]
// datapath of the base-n digit counter: config registers, digit store,
// radix divider (eight quotient bits a cycle), carry ripple and result registers
// depends on bndc_pkg
module bndc_dpath import bndc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  logic [LOAD_W-1:0]      req_load_value,
   input  logic [DIGIT_IDX_W-1:0] req_position,
   input  logic                   req_use_last_position,
   input  logic                   req_just_increment,
   input  logic [NUM_W-1:0]       req_new_digit,
   input  logic                   csr_write_enable,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_write_data,
   output logic [1:0]             rsp_status,
   output logic [WORD_W-1:0]      rsp_digit_word
);

   logic [CFG_W-1:0]       radix_ff, radix_in;
   logic [CFG_W-1:0]       count_ff, count_in;
   logic [DIGIT_BITS-1:0]  digits_ff [MAX_DIGITS];
   logic [DIGIT_BITS-1:0]  digits_in [MAX_DIGITS];
   logic [WORK_W-1:0]      work_ff, work_in;
   logic [NUM_W-1:0]       rem_ff, rem_in;
   logic [PASS_W-1:0]      pass_ff, pass_in;
   logic [DIGIT_IDX_W-1:0] idx_ff, idx_in;
   logic [DIGIT_IDX_W-1:0] pos_ff, pos_in;
   logic                   inc_ff, inc_in;
   logic [NUM_W-1:0]       nd_ff, nd_in;
   logic [NUM_W-1:0]       v_ff, v_in;
   status_type             status_ff, status_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]      rsp_word_ff, rsp_word_in;

   logic [NUM_W-1:0]       r_eff;
   logic [CNT_W-1:0]       n_eff;
   logic [DIGIT_IDX_W-1:0] last_pos;
   logic [NUM_W-1:0]       div_rem;
   logic [WORK_W-1:0]      div_work;
   logic                   pass_last;
   logic [DIGIT_IDX_W-1:0] rd_addr;
   logic [DIGIT_BITS-1:0]  rd_digit;
   logic                   v_lt;
   logic [WORD_W-1:0]      pack_word;

   // clamp config to legal range
   always_comb begin
      if (radix_ff < NUM_W'(RADIX_MIN)) r_eff = NUM_W'(RADIX_MIN);
      else if (radix_ff > NUM_W'(RADIX_MAX)) r_eff = NUM_W'(RADIX_MAX);
      else r_eff = radix_ff;
      if (count_ff == '0) n_eff = CNT_W'(1);
      else if (count_ff > CNT_W'(MAX_DIGITS)) n_eff = CNT_W'(MAX_DIGITS);
      else n_eff = count_ff;
   end

   assign last_pos = DIGIT_IDX_W'(n_eff - CNT_W'(1));

   // restoring division, msb first, remainder stays below radix
   always_comb begin
      div_rem  = rem_ff;
      div_work = work_ff;
      for (int k = 0; k < DIV_STEPS; k++) begin
         div_rem  = {div_rem[NUM_W-2:0], div_work[WORK_W-1]};
         div_work = {div_work[WORK_W-2:0], 1'b0};
         if (div_rem >= r_eff) begin
            div_rem     = div_rem - r_eff;
            div_work[0] = 1'b1;
         end
      end
   end

   assign pass_last = (pass_ff == PASS_W'(DIV_PASSES - 1));
   assign rd_addr   = cmd.carry_run ? (pos_ff - DIGIT_IDX_W'(1)) : pos_ff;
   assign rd_digit  = digits_ff[rd_addr];
   assign v_lt      = (v_ff < r_eff);

   assign sts.div_last   = pass_last && (idx_ff == '0);
   assign sts.bad        = ({1'b0, pos_ff} >= n_eff) || (!inc_ff && (nd_ff > r_eff));
   assign sts.carry_stop = v_lt || (pos_ff == '0);

   always_comb begin
      pack_word = '0;
      for (int p = 0; p < MAX_DIGITS; p++) begin
         if (CNT_W'(p) < n_eff) pack_word[p*DIGIT_BITS +: DIGIT_BITS] = digits_ff[p];
      end
   end

   always_comb begin
      radix_in      = radix_ff;
      count_in      = count_ff;
      digits_in     = digits_ff;
      work_in       = work_ff;
      rem_in        = rem_ff;
      pass_in       = pass_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      inc_in        = inc_ff;
      nd_in         = nd_ff;
      v_in          = v_ff;
      status_in     = status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_word_in   = rsp_word_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_RADIX:  radix_in = csr_write_data;
            CSR_DIGITS: count_in = csr_write_data;
            default: ;
         endcase
      end

      if (cmd.capture) begin
         work_in   = WORK_W'(req_load_value);
         rem_in    = '0;
         pass_in   = '0;
         idx_in    = last_pos;
         pos_in    = req_use_last_position ? last_pos : req_position;
         inc_in    = req_just_increment;
         nd_in     = req_new_digit;
         status_in = ST_OK;
      end

      if (cmd.div_run) begin
         work_in = div_work;
         rem_in  = div_rem;
         pass_in = pass_ff + PASS_W'(1);
         if (pass_last) begin
            digits_in[idx_ff] = div_rem[DIGIT_BITS-1:0];
            rem_in            = '0;
            idx_in            = idx_ff - DIGIT_IDX_W'(1);
            if (idx_ff == '0) status_in = (div_work != '0) ? ST_BIG : ST_OK;
         end
      end

      if (cmd.step_begin) begin
         if (sts.bad) begin
            status_in = ST_BAD;
         end else begin
            for (int p = 0; p < MAX_DIGITS; p++) begin
               if ((CNT_W'(p) > {1'b0, pos_ff}) && (CNT_W'(p) < n_eff)) digits_in[p] = '0;
            end
            v_in = inc_ff ? (NUM_W'(rd_digit) + NUM_W'(1)) : nd_ff;
         end
      end

      if (cmd.carry_run) begin
         if (v_lt) begin
            digits_in[pos_ff] = v_ff[DIGIT_BITS-1:0];
            status_in         = ST_OK;
         end else if (pos_ff == '0) begin
            for (int p = 0; p < MAX_DIGITS; p++) begin
               if (CNT_W'(p) < n_eff) digits_in[p] = '0;
            end
            status_in = ST_WRAP;
         end else begin
            digits_in[pos_ff] = '0;
            pos_in            = pos_ff - DIGIT_IDX_W'(1);
            v_in              = NUM_W'(rd_digit) + NUM_W'(1);
         end
      end

      if (cmd.publish) begin
         rsp_status_in = status_ff;
         rsp_word_in   = pack_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= CFG_W'(RADIX_RESET);
         count_ff <= CFG_W'(COUNT_RESET);
         for (int p = 0; p < MAX_DIGITS; p++) digits_ff[p] <= '0;
      end else begin
         radix_ff  <= radix_in;
         count_ff  <= count_in;
         digits_ff <= digits_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff       <= work_in;
      rem_ff        <= rem_in;
      pass_ff       <= pass_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      inc_ff        <= inc_in;
      nd_ff         <= nd_in;
      v_ff          <= v_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_digit_word = rsp_word_ff;

endmodule

[rtl/base_n_digit_counter.sv]
// top level of the base-n digit counter (odometer)
// depends on bndc_pkg, bndc_ctrl, bndc_dpath, base_n_digit_counter_assert.svh
//
//  channel   handshake             payload
//  req       start, busy           req_op, req_load_value, req_position,
//                                  req_use_last_position, req_just_increment,
//                                  req_new_digit
//  rsp       rsp_valid (strobe)    rsp_status, rsp_digit_word
//  csr       csr_write_enable      csr_index, csr_write_data
//
// a load converts the value digit by digit, from the last active position down: the
// shared radix divider yields eight quotient bits a cycle, four passes per digit
// a step ripples its carry from the chosen position toward digit 0
// the result strobe comes in the cycle busy drops; a new start is taken there
// reset clears config to radix 2, eight digits, and all digits to zero
`include "base_n_digit_counter_assert.svh"

module base_n_digit_counter import bndc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_op,
   input  logic [LOAD_W-1:0]      req_load_value,
   input  logic [DIGIT_IDX_W-1:0] req_position,
   input  logic                   req_use_last_position,
   input  logic                   req_just_increment,
   input  logic [NUM_W-1:0]       req_new_digit,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [WORD_W-1:0]      rsp_digit_word,
   input  logic                   csr_write_enable,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_write_data
);

   cmd_type cmd;
   sts_type sts;

   bndc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (req_op),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   bndc_dpath u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_load_value        (req_load_value),
      .req_position          (req_position),
      .req_use_last_position (req_use_last_position),
      .req_just_increment    (req_just_increment),
      .req_new_digit         (req_new_digit),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .rsp_status            (rsp_status),
      .rsp_digit_word        (rsp_digit_word)
   );

   `BNDC_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `BNDC_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "transfer not taken")
   `BNDC_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result strobe repeated")
   `BNDC_ASSERT_NOW(a_done_rsp, clock, reset, $fell(busy) && !$past(reset), rsp_valid, "item ended without result")

endmodule
